@@ src/sbc_pkg.sv @@
// Shared types and constants of the sector buffer cache controller.
// Depends on nothing; every other file imports it.
package sbc_pkg;

   localparam int NUM_WAYS_DEF     = 64;
   localparam int SECTOR_BYTES_DEF = 512;
   localparam int MAX_RESULTS      = 64;

   localparam logic [1:0] MODE_READ  = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_FLUSH = 2'd2;

   localparam logic [1:0] KIND_READ     = 2'd0;
   localparam logic [1:0] KIND_WRITE    = 2'd1;
   localparam logic [1:0] KIND_PREFETCH = 2'd2;
   localparam logic [1:0] KIND_FLUSH    = 2'd3;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] sector;
      logic [8:0]  byte_offset;
      logic [9:0]  byte_count;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [5:0]  way;
      logic        hit;
      logic        fill_read;
      logic        writeback;
      logic [31:0] writeback_sector;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] tag;
      logic        valid;
      logic        dirty;
      logic        accessed;
   } entry_type;

endpackage

@@ src/sbc_cell.sv @@
// One way of the rotating tag ring: holds a tag with its marks.
// Depends on sbc_pkg.
module sbc_cell (
   input  logic               clock,
   input  logic               reset,
   input  sbc_pkg::entry_type d,
   output sbc_pkg::entry_type q
);
   import sbc_pkg::*;

   entry_type entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= d;
      end
   end

   assign q = entry_ff;

endmodule

@@ src/sector_buffer_cache_controller.sv @@
// Top level of the sector buffer cache controller: ring of way cells and sequencer.
// Depends on sbc_pkg and sbc_cell.
//
//   channel   ports                           handshake
//   request   start, busy, req_data           start high while busy low
//   result    rsp_strobe, rsp_data            one strobe per word, no back-pressure
//   config    csr_valid, csr_ready, csr_data  valid and ready high
//
// The ways rotate through the ring by one cell every cycle, so each access makes a
// search pass over all ways and then waits for the chosen way to come round to the
// head to be updated; a read with prefetch also searches for the next sector.
// A flush waits for way 0 and walks every way, one report word per dirty way.
// Reset clears every way; results are never stalled.
module sector_buffer_cache_controller #(
   parameter int NUM_WAYS     = sbc_pkg::NUM_WAYS_DEF,
   parameter int SECTOR_BYTES = sbc_pkg::SECTOR_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  sbc_pkg::req_type req_data,
   output logic             rsp_strobe,
   output sbc_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [31:0]      csr_data
);
   import sbc_pkg::*;

   localparam int WI  = $clog2(NUM_WAYS);
   localparam int IW  = $clog2(NUM_WAYS + 1);
   localparam int FCW = $clog2(MAX_RESULTS + 1);
   localparam logic [WI-1:0] LAST_WAY = WI'(NUM_WAYS - 1);
   localparam logic [IW-1:0] WAYS_U   = IW'(NUM_WAYS);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_UPD    = 3'd3;
   localparam logic [2:0] ST_EMIT   = 3'd4;
   localparam logic [2:0] ST_FLWAIT = 3'd5;
   localparam logic [2:0] ST_FLUSH  = 3'd6;
   localparam logic [2:0] ST_FLLAST = 3'd7;

   entry_type ring_q [NUM_WAYS];
   entry_type head;
   entry_type tail_in;

   logic [2:0]    state_ff, state_in;
   logic [WI-1:0] pos_ff, pos_in;
   logic [WI-1:0] scan_ff, scan_in;
   logic [IW-1:0] inuse_ff, inuse_in;
   logic [31:0]   disk_ff, disk_in;
   req_type       req_ff, req_in;
   logic [31:0]   sec_ff, sec_in;
   logic          pf_ff, pf_in;
   logic          mfound_ff, mfound_in;
   logic [WI-1:0] midx_ff, midx_in;
   logic [3:0]    cfound_ff, cfound_in;
   logic [WI-1:0] cidx_ff [4];
   logic [WI-1:0] cidx_in [4];
   logic [WI-1:0] tgt_ff, tgt_in;
   logic          hit_ff, hit_in;
   logic          alloc_ff, alloc_in;
   logic          upd_in;
   logic          wb_ff, wb_in;
   logic [31:0]   wbsec_ff, wbsec_in;
   logic          pend_ff, pend_in;
   logic [WI-1:0] pway_ff, pway_in;
   logic [31:0]   ptag_ff, ptag_in;
   logic [FCW-1:0] fcnt_ff, fcnt_in;
   logic          strobe_ff, strobe_in;
   rsp_type       rsp_ff, rsp_in;

   logic [WI-1:0] victim;
   logic [1:0]    cls;
   logic          pf_cond;
   logic          fill_w;

   genvar gi;
   generate
      for (gi = 0; gi < NUM_WAYS; gi++) begin : g_ring
         if (gi == NUM_WAYS - 1) begin : g_tail
            sbc_cell u_cell (.clock(clock), .reset(reset), .d(tail_in), .q(ring_q[gi]));
         end else begin : g_body
            sbc_cell u_cell (.clock(clock), .reset(reset), .d(ring_q[gi+1]),
                             .q(ring_q[gi]));
         end
      end
   endgenerate

   assign head      = ring_q[0];
   assign cls       = {head.dirty, head.accessed};
   assign pf_cond   = ({1'b0, req_ff.sector} + 33'd1) < {1'b0, disk_ff};
   assign fill_w    = (req_ff.byte_offset != 9'd0) ||
                      (32'(req_ff.byte_count) < 32'(SECTOR_BYTES));
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      if (cfound_ff[0]) begin
         victim = cidx_ff[0];
      end else if (cfound_ff[1]) begin
         victim = cidx_ff[1];
      end else if (cfound_ff[2]) begin
         victim = cidx_ff[2];
      end else begin
         victim = cidx_ff[3];
      end
   end

   always_comb begin
      state_in  = state_ff;
      pos_in    = (pos_ff == LAST_WAY) ? '0 : pos_ff + 1'b1;
      scan_in   = (scan_ff == LAST_WAY) ? '0 : scan_ff + 1'b1;
      inuse_in  = inuse_ff;
      disk_in   = (csr_valid && csr_ready) ? csr_data : disk_ff;
      req_in    = req_ff;
      sec_in    = sec_ff;
      pf_in     = pf_ff;
      mfound_in = mfound_ff;
      midx_in   = midx_ff;
      cfound_in = cfound_ff;
      cidx_in   = cidx_ff;
      tgt_in    = tgt_ff;
      hit_in    = hit_ff;
      alloc_in  = alloc_ff;
      upd_in    = 1'b0;
      wb_in     = wb_ff;
      wbsec_in  = wbsec_ff;
      pend_in   = pend_ff;
      pway_in   = pway_ff;
      ptag_in   = ptag_ff;
      fcnt_in   = fcnt_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      tail_in   = head;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in    = req_data;
               sec_in    = req_data.sector;
               pf_in     = 1'b0;
               scan_in   = '0;
               mfound_in = 1'b0;
               cfound_in = '0;
               pend_in   = 1'b0;
               fcnt_in   = '0;
               if (req_data.mode == MODE_READ || req_data.mode == MODE_WRITE) begin
                  state_in = ST_SCAN;
               end else if (req_data.mode == MODE_FLUSH) begin
                  state_in = ST_FLWAIT;
               end else begin
                  state_in = ST_FLLAST;
               end
            end
         end
         ST_SCAN: begin
            if (head.valid && head.tag == sec_ff && (!mfound_ff || pos_ff < midx_ff)) begin
               mfound_in = 1'b1;
               midx_in   = pos_ff;
            end
            if (!cfound_ff[cls] || pos_ff < cidx_ff[cls]) begin
               cfound_in[cls] = 1'b1;
               cidx_in[cls]   = pos_ff;
            end
            if (scan_ff == LAST_WAY) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            wb_in    = 1'b0;
            wbsec_in = '0;
            hit_in   = mfound_ff;
            alloc_in = !mfound_ff;
            upd_in   = 1'b1;
            if (mfound_ff) begin
               tgt_in = midx_ff;
               if (pf_ff) begin
                  upd_in = 1'b0;
               end
            end else if (inuse_ff < WAYS_U) begin
               tgt_in   = inuse_ff[WI-1:0];
               inuse_in = inuse_ff + 1'b1;
            end else begin
               tgt_in = victim;
            end
            state_in = upd_in ? ST_UPD : ST_EMIT;
         end
         ST_UPD: begin
            if (pos_ff == tgt_ff) begin
               if (alloc_ff) begin
                  wb_in    = head.dirty;
                  wbsec_in = head.dirty ? head.tag : 32'd0;
                  tail_in.tag   = sec_ff;
                  tail_in.valid = 1'b1;
                  if (req_ff.mode == MODE_WRITE) begin
                     tail_in.dirty    = 1'b1;
                     tail_in.accessed = 1'b0;
                  end else begin
                     tail_in.dirty    = 1'b0;
                     tail_in.accessed = 1'b1;
                  end
               end else if (req_ff.mode == MODE_WRITE) begin
                  tail_in.dirty = 1'b1;
               end else begin
                  tail_in.accessed = 1'b1;
               end
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            strobe_in               = 1'b1;
            rsp_in.way              = 6'(tgt_ff);
            rsp_in.hit              = hit_ff;
            rsp_in.writeback        = wb_ff;
            rsp_in.writeback_sector = wbsec_ff;
            if (req_ff.mode == MODE_WRITE) begin
               rsp_in.kind      = KIND_WRITE;
               rsp_in.fill_read = !hit_ff && fill_w;
               rsp_in.last      = 1'b1;
               state_in         = ST_IDLE;
            end else begin
               rsp_in.kind      = pf_ff ? KIND_PREFETCH : KIND_READ;
               rsp_in.fill_read = !hit_ff;
               rsp_in.last      = pf_ff || !pf_cond;
               if (!pf_ff && pf_cond) begin
                  pf_in     = 1'b1;
                  sec_in    = req_ff.sector + 32'd1;
                  scan_in   = '0;
                  mfound_in = 1'b0;
                  cfound_in = '0;
                  state_in  = ST_SCAN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FLWAIT: begin
            scan_in = '0;
            if (pos_ff == LAST_WAY) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (head.valid && head.dirty) begin
               if (pend_ff) begin
                  strobe_in               = 1'b1;
                  rsp_in.kind             = KIND_FLUSH;
                  rsp_in.way              = 6'(pway_ff);
                  rsp_in.hit              = 1'b0;
                  rsp_in.fill_read        = 1'b0;
                  rsp_in.writeback        = 1'b1;
                  rsp_in.writeback_sector = ptag_ff;
                  rsp_in.last             = 1'b0;
               end
               pend_in = 1'b1;
               pway_in = pos_ff;
               ptag_in = head.tag;
               fcnt_in = fcnt_ff + 1'b1;
               if (fcnt_ff == FCW'(MAX_RESULTS - 1)) begin
                  state_in = ST_FLLAST;
               end
            end
            if (scan_ff == LAST_WAY) begin
               state_in = ST_FLLAST;
            end
         end
         ST_FLLAST: begin
            if (pend_ff) begin
               strobe_in               = 1'b1;
               rsp_in.kind             = KIND_FLUSH;
               rsp_in.way              = 6'(pway_ff);
               rsp_in.hit              = 1'b0;
               rsp_in.fill_read        = 1'b0;
               rsp_in.writeback        = 1'b1;
               rsp_in.writeback_sector = ptag_ff;
               rsp_in.last             = 1'b1;
            end
            pend_in  = 1'b0;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pos_ff    <= '0;
         scan_ff   <= '0;
         inuse_ff  <= '0;
         disk_ff   <= '0;
         pend_ff   <= 1'b0;
         fcnt_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pos_ff    <= pos_in;
         scan_ff   <= scan_in;
         inuse_ff  <= inuse_in;
         disk_ff   <= disk_in;
         pend_ff   <= pend_in;
         fcnt_ff   <= fcnt_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      sec_ff    <= sec_in;
      pf_ff     <= pf_in;
      mfound_ff <= mfound_in;
      midx_ff   <= midx_in;
      cfound_ff <= cfound_in;
      cidx_ff   <= cidx_in;
      tgt_ff    <= tgt_in;
      hit_ff    <= hit_in;
      alloc_ff  <= alloc_in;
      wb_ff     <= wb_in;
      wbsec_ff  <= wbsec_in;
      pway_ff   <= pway_in;
      ptag_ff   <= ptag_in;
      rsp_ff    <= rsp_in;
   end

endmodule

@@ src/sbc_checker.sv @@
// Port-level checks for the sector buffer cache controller, bound to the top level.
// Depends on sbc_pkg and sector_buffer_cache_controller.
module sbc_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input sbc_pkg::rsp_type rsp_data
);
   import sbc_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("Accepted word did not make the block busy.");

   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last |-> busy)
      else $error("Block went idle before the final result word.");

   a_wb_sector: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.writeback |-> rsp_data.writeback_sector == 32'd0)
      else $error("Writeback sector set without writeback.");

   a_flush_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.kind == KIND_FLUSH |->
         rsp_data.writeback && !rsp_data.hit && !rsp_data.fill_read)
      else $error("Malformed flush report word.");

endmodule

bind sector_buffer_cache_controller sbc_checker u_sbc_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
);

@@ test/sector_buffer_cache_controller_test.sv @@
// Self-checking test of sector_buffer_cache_controller: directed and random sector words
// are checked against a scoreboard that predicts tags, marks and replacement choices.
// Depends on sbc_pkg and the controller RTL.
`timescale 1ns / 100ps

module sector_buffer_cache_controller_test;
   import sbc_pkg::*;

   localparam int WAYS = 64;
   localparam int SETTLE = 300;
   localparam int STALL_LIMIT = 3000;

   class cache_scoreboard;
      logic [31:0] tag[WAYS];
      bit          valid[WAYS];
      bit          dirty[WAYS];
      bit          acc[WAYS];
      int          used;
      logic [31:0] disk;
      rsp_type     pending[$];
      int          errors;

      function void clear();
         for (int i = 0; i < WAYS; i++) begin
            tag[i] = '0;
            valid[i] = 0;
            dirty[i] = 0;
            acc[i] = 0;
         end
         used = 0;
         disk = '0;
         errors = 0;
      endfunction

      function int find(logic [31:0] sec);
         for (int i = 0; i < WAYS; i++)
            if (valid[i] && tag[i] == sec) return i;
         return -1;
      endfunction

      function int pick_victim(output bit wb, output logic [31:0] wbsec);
         wb = 0;
         wbsec = '0;
         if (used < WAYS) begin
            used++;
            return used - 1;
         end
         for (int cls = 0; cls < 4; cls++)
            for (int i = 0; i < WAYS; i++)
               if (dirty[i] == (cls >= 2) && acc[i] == cls[0]) begin
                  if (dirty[i]) begin
                     wb = 1;
                     wbsec = tag[i];
                  end
                  return i;
               end
         return 0;
      endfunction

      function rsp_type fetch_sector(logic [31:0] sec, logic [1:0] kind, bit ahead);
         rsp_type r;
         int m;
         int w;
         bit wb;
         logic [31:0] wbsec;
         r = '0;
         r.kind = kind;
         m = find(sec);
         if (m >= 0) begin
            r.hit = 1;
            r.way = m[5:0];
            if (!ahead) acc[m] = 1;
            return r;
         end
         w = pick_victim(wb, wbsec);
         tag[w] = sec;
         valid[w] = 1;
         dirty[w] = 0;
         acc[w] = 1;
         r.way = w[5:0];
         r.fill_read = 1;
         r.writeback = wb;
         r.writeback_sector = wbsec;
         return r;
      endfunction

      function void note_request(req_type q);
         rsp_type outs[$];
         rsp_type r;
         int m;
         int w;
         bit wb;
         logic [31:0] wbsec;
         if (q.mode == MODE_READ) begin
            outs.push_back(fetch_sector(q.sector, KIND_READ, 0));
            if ({1'b0, q.sector} + 33'd1 < {1'b0, disk})
               outs.push_back(fetch_sector(q.sector + 32'd1, KIND_PREFETCH, 1));
         end else if (q.mode == MODE_WRITE) begin
            r = '0;
            r.kind = KIND_WRITE;
            m = find(q.sector);
            if (m >= 0) begin
               dirty[m] = 1;
               r.way = m[5:0];
               r.hit = 1;
            end else begin
               w = pick_victim(wb, wbsec);
               tag[w] = q.sector;
               valid[w] = 1;
               dirty[w] = 1;
               acc[w] = 0;
               r.way = w[5:0];
               r.fill_read = (q.byte_offset != 0 || q.byte_count < 10'd512);
               r.writeback = wb;
               r.writeback_sector = wbsec;
            end
            outs.push_back(r);
         end else if (q.mode == MODE_FLUSH) begin
            for (int i = 0; i < WAYS && i < used && outs.size() < MAX_RESULTS; i++)
               if (valid[i] && dirty[i]) begin
                  r = '0;
                  r.kind = KIND_FLUSH;
                  r.way = i[5:0];
                  r.writeback = 1;
                  r.writeback_sector = tag[i];
                  outs.push_back(r);
               end
         end
         if (outs.size() > 0) outs[outs.size() - 1].last = 1;
         foreach (outs[k]) pending.push_back(outs[k]);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected word, expected none, actual %h", $time, got);
            return;
         end
         want = pending.pop_front();
         if (got.kind !== want.kind || got.way !== want.way || got.hit !== want.hit
             || got.fill_read !== want.fill_read || got.writeback !== want.writeback
             || got.writeback_sector !== want.writeback_sector || got.last !== want.last) begin
            errors++;
            $display("%0t: mismatch, expected %h, actual %h", $time, want, got);
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [31:0] csr_data;

   cache_scoreboard sb;
   int  stall_count;
   bit  no_gaps;

   sector_buffer_cache_controller dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_result(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   task automatic send_word(logic [1:0] mode, logic [31:0] sector, logic [8:0] ofs,
                            logic [9:0] cnt);
      @(negedge clock);
      start = 0;
      while (busy) @(negedge clock);
      while (!no_gaps && $urandom_range(99) < 16) @(negedge clock);
      start = 1;
      req_data.mode = mode;
      req_data.sector = sector;
      req_data.byte_offset = ofs;
      req_data.byte_count = cnt;
      do @(posedge clock); while (busy);
      sb.note_request(req_data);
   endtask

   task automatic drain();
      @(negedge clock);
      start = 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_disk_size(logic [31:0] value);
      @(negedge clock);
      csr_valid = 1;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      sb.disk = value;
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic random_words(int count, logic [31:0] pool);
      int pick;
      logic [31:0] sec;
      logic [9:0] cnt;
      for (int n = 0; n < count; n++) begin
         no_gaps = (n >= 15 && n < 40);
         if (n == 50) drain();
         pick = $urandom_range(99);
         sec = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(pool);
         cnt = ($urandom_range(2) == 0) ? 10'd512 : 10'($urandom_range(512));
         if (pick < 46)
            send_word(MODE_READ, sec, 9'($urandom_range(511)), cnt);
         else if (pick < 92)
            send_word(MODE_WRITE, sec, ($urandom_range(1) == 0) ? 9'd0
                      : 9'($urandom_range(511)), cnt);
         else if (pick < 97)
            send_word(MODE_FLUSH, $urandom(), 9'($urandom_range(511)), cnt);
         else
            send_word(2'd3, $urandom(), 9'($urandom_range(511)), cnt);
      end
      no_gaps = 0;
   endtask

   initial begin
      sb = new();
      sb.clear();
      clock = 0;
      reset = 1;
      start = 0;
      req_data = '0;
      csr_valid = 0;
      csr_data = '0;
      stall_count = 0;
      no_gaps = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      send_word(MODE_READ, 32'd0, 9'd0, 10'd512);
      send_word(MODE_READ, 32'hFFFF_FFFF, 9'd511, 10'd0);
      send_word(MODE_WRITE, 32'd7, 9'd0, 10'd512);
      send_word(MODE_WRITE, 32'd8, 9'd511, 10'd1);
      send_word(MODE_WRITE, 32'd9, 9'd0, 10'd0);
      send_word(MODE_WRITE, 32'd0, 9'd0, 10'd512);
      send_word(MODE_READ, 32'd7, 9'd0, 10'd512);
      send_word(MODE_FLUSH, 32'd0, 9'd0, 10'd0);
      send_word(2'd3, 32'hFFFF_FFFF, 9'h1FF, 10'h3FF);
      drain();
      write_disk_size(32'hFFFF_FFFF);
      send_word(MODE_READ, 32'd8, 9'd0, 10'd512);
      send_word(MODE_READ, 32'd20, 9'd0, 10'd512);
      send_word(MODE_READ, 32'hFFFF_FFFE, 9'd0, 10'd512);
      send_word(MODE_READ, 32'hFFFF_FFFF, 9'd0, 10'd512);
      send_word(MODE_WRITE, 32'd21, 9'd256, 10'd256);
      send_word(MODE_FLUSH, 32'd0, 9'd0, 10'd0);
      drain();

      write_disk_size(32'd90);
      random_words(60, 32'd120);
      drain();
      write_disk_size(32'd0);
      random_words(30, 32'd100);
      drain();
      write_disk_size(32'hFFFF_FFFF);
      random_words(30, 32'd110);
      send_word(MODE_FLUSH, 32'd0, 9'd0, 10'd0);

      drain();
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/sbc_pkg.sv
src/sbc_cell.sv
src/sector_buffer_cache_controller.sv
src/sbc_checker.sv
test/sector_buffer_cache_controller_test.sv
